[rtl/mwc_pkg.sv]
// Package with constants, types and helper functions for the multiply-with-carry generator.
`default_nettype none

package mwc_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned HalfW = 16;

	localparam logic MODE_SEED = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	localparam logic [WordW-1:0] BAD_W     = 32'h464f_ffff;
	localparam logic [WordW-1:0] BAD_Z     = 32'h9068_ffff;
	localparam logic [HalfW-1:0] MUL_Z     = 16'd36969;
	localparam logic [HalfW-1:0] MUL_W     = 16'd18000;
	localparam logic [WordW-1:0] HASH_XOR  = 32'd61;
	localparam logic [WordW-1:0] HASH_MUL2 = 32'h27d4_eb2d;
	localparam logic [WordW-1:0] STREAM_RESET = 32'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_LOAD
	} mwc_state_t;

	typedef struct packed {
		logic pre;
		logic mul_a;
		logic mul_b;
		logic load;
		logic draw;
	} mwc_cmd_t;

	// First half of the integer hash, up to the big multiply. The times-nine
	// step is a shift and add.
	function automatic logic [WordW-1:0] hash_pre(input logic [WordW-1:0] s);
		logic [WordW-1:0] t;
		t = (s ^ HASH_XOR) ^ (s >> 16);
		t = t + (t << 3);
		t = t ^ (t >> 4);
		return t;
	endfunction

	function automatic logic [WordW-1:0] hash_post(input logic [WordW-1:0] t);
		return t ^ (t >> 15);
	endfunction

	// One multiply-with-carry step, modulo 2^32.
	function automatic logic [WordW-1:0] mwc_step(input logic [WordW-1:0] x,
			input logic [HalfW-1:0] mul);
		logic [WordW-1:0] prod;
		prod = {{(WordW-HalfW){1'b0}}, mul} * {{(WordW-HalfW){1'b0}}, x[HalfW-1:0]};
		return prod + {{(WordW-HalfW){1'b0}}, x[WordW-1:HalfW]};
	endfunction

endpackage

`default_nettype wire

[rtl/mwc_random_generator.sv]
// Latency: a draw item shows its word in the cycle after it is accepted.
// Throughput: draws are taken one per cycle while no seed is in progress and the output side keeps up.
// A seed item holds off further input through its steps: hash front end, then the single
// shared 32x32 hash multiplier for each stream in turn, then the load of both streams.
// Reset (arst_n low) sets both stream words to one and drops any pending result.
`default_nettype none

module mwc_random_generator
	import mwc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             mode,
	input  wire logic [WordW-1:0] seed_a,
	input  wire logic [WordW-1:0] seed_b,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [WordW-1:0] random_word
);

	mwc_cmd_t cmd;

	mwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mwc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_a      (seed_a),
		.seed_b      (seed_b),
		.random_word (random_word)
	);

endmodule

`default_nettype wire

[rtl/mwc_ctrl.sv]
// Controller state machine: input and output handshakes and the seed-load sequence.
`default_nettype none

module mwc_ctrl
	import mwc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     mode,
	output logic          out_valid,
	input  wire logic     out_ready,
	output mwc_cmd_t      cmd
);

	mwc_state_t state_q, state_d;
	logic       out_valid_q;
	logic       in_fire;

	// A new item may enter while a result waits, as long as it is taken this cycle
	// or the item does not produce one.
	always_comb begin
		in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready || mode == MODE_SEED);
		in_fire  = in_valid && in_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && mode == MODE_SEED) begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.pre  = in_fire && mode == MODE_SEED;
				cmd.draw = in_fire && mode == MODE_DRAW;
			end
			ST_MUL_A: cmd.mul_a = 1'b1;
			ST_MUL_B: cmd.mul_b = 1'b1;
			ST_LOAD:  cmd.load  = 1'b1;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.draw) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/mwc_datapath.sv]
// Datapath: stream words, shared hash multiplier and the output word register.
`default_nettype none

module mwc_datapath
	import mwc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mwc_cmd_t         cmd,
	input  wire logic [WordW-1:0] seed_a,
	input  wire logic [WordW-1:0] seed_b,
	output logic      [WordW-1:0] random_word
);

	logic [WordW-1:0] w_q, z_q;
	logic [WordW-1:0] ha_q, hb_q;
	logic [WordW-1:0] word_q;
	logic [WordW-1:0] mul_in, mul_out;
	logic [WordW-1:0] w_next, z_next;
	logic [WordW-1:0] w_hash, z_hash, w_seed, z_seed;

	// One 32x32 multiplier serves both hash lanes on consecutive cycles.
	always_comb begin
		mul_in  = cmd.mul_b ? hb_q : ha_q;
		mul_out = mul_in * HASH_MUL2;
	end

	always_comb begin
		w_next = mwc_step(w_q, MUL_W);
		z_next = mwc_step(z_q, MUL_Z);
		w_hash = hash_post(ha_q);
		z_hash = hash_post(hb_q);
		w_seed = (w_hash == '0 || w_hash == BAD_W) ? w_hash + 32'd1 : w_hash;
		z_seed = (z_hash == '0 || z_hash == BAD_Z) ? z_hash + 32'd1 : z_hash;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= STREAM_RESET;
			z_q <= STREAM_RESET;
		end else if (cmd.draw) begin
			w_q <= w_next;
			z_q <= z_next;
		end else if (cmd.load) begin
			w_q <= w_seed;
			z_q <= z_seed;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pre) begin
			ha_q <= hash_pre(seed_a);
			hb_q <= hash_pre(seed_b);
		end
		if (cmd.mul_a) begin
			ha_q <= mul_out;
		end
		if (cmd.mul_b) begin
			hb_q <= mul_out;
		end
		if (cmd.draw) begin
			word_q <= {z_next[HalfW-1:0], {HalfW{1'b0}}} + w_next;
		end
	end

	assign random_word = word_q;

endmodule

`default_nettype wire

[tb/mwc_checker.sv]
// Checker for the multiply-with-carry generator: predicts each drawn word and compares outputs.
`timescale 1ns / 1ps

module mwc_checker
	import mwc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             mode,
	input  logic [WordW-1:0] seed_a,
	input  logic [WordW-1:0] seed_b,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [WordW-1:0] random_word,
	output int               fail_count,
	output int               pending
);

	localparam logic [WordW-1:0] HASH_TIMES = 32'd9;

	logic [WordW-1:0] w_state;
	logic [WordW-1:0] z_state;
	logic [WordW-1:0] hashed_w;
	logic [WordW-1:0] hashed_z;
	logic [WordW-1:0] want;
	logic [WordW-1:0] expected_words[$];

	function automatic logic [WordW-1:0] seed_hash(input logic [WordW-1:0] s);
		logic [WordW-1:0] t;
		t = (s ^ HASH_XOR) ^ (s >> 16);
		t = t * HASH_TIMES;
		t = t ^ (t >> 4);
		t = t * HASH_MUL2;
		t = t ^ (t >> 15);
		return t;
	endfunction

	function automatic logic [WordW-1:0] mwc_advance(input logic [WordW-1:0] x,
			input logic [HalfW-1:0] mul);
		logic [WordW-1:0] prod;
		prod = {16'd0, mul} * {16'd0, x[HalfW-1:0]};
		return prod + (x >> HalfW);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_state = STREAM_RESET;
			z_state = STREAM_RESET;
			expected_words.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (mode == MODE_SEED) begin
					hashed_w = seed_hash(seed_a);
					hashed_z = seed_hash(seed_b);
					// Each stream has its own bad value; the z test is made on z.
					if (hashed_w == '0 || hashed_w == BAD_W) begin
						hashed_w = hashed_w + 1;
					end
					if (hashed_z == '0 || hashed_z == BAD_Z) begin
						hashed_z = hashed_z + 1;
					end
					w_state = hashed_w;
					z_state = hashed_z;
				end else begin
					z_state = mwc_advance(z_state, MUL_Z);
					w_state = mwc_advance(w_state, MUL_W);
					expected_words.push_back((z_state << HalfW) + w_state);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: random_word mismatch, expected none, actual %h",
						$time, random_word);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_words.pop_front();
					if (random_word !== want) begin
						$display("%0t: random_word mismatch, expected %h, actual %h",
							$time, want, random_word);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

[tb/tb_top.sv]
// Top of the testbench: clock, reset, stimulus, watchdog and verdict for the generator.
`timescale 1ns / 1ps

module tb_top
	import mwc_pkg::*;
();

	localparam int unsigned    RANDOM_ITEMS   = 1400;
	localparam int unsigned    WATCHDOG_LIMIT = 2000;
	localparam int unsigned    DRAIN_CYCLES   = 10;
	localparam logic [WordW-1:0] HASH_TIMES   = 32'd9;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             mode = MODE_SEED;
	logic [WordW-1:0] seed_a = '0;
	logic [WordW-1:0] seed_b = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [WordW-1:0] random_word;
	logic             no_idle = 1'b0;
	int               fail_count;
	int               pending;
	int unsigned      idle_cycles = 0;

	mwc_random_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.seed_a     (seed_a),
		.seed_b     (seed_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_word(random_word)
	);

	mwc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.seed_a     (seed_a),
		.seed_b     (seed_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_word(random_word),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Every hash stage is invertible, so seeds that hash onto the bad values
	// can be computed directly.
	function automatic logic [WordW-1:0] undo_xorshift(input logic [WordW-1:0] y,
			input int unsigned k);
		logic [WordW-1:0] x;
		x = y;
		for (int i = 0; i < 32; i++) x = y ^ (x >> k);
		return x;
	endfunction

	function automatic logic [WordW-1:0] odd_inverse(input logic [WordW-1:0] a);
		logic [WordW-1:0] r;
		r = a;
		for (int i = 0; i < 5; i++) r = r * (32'd2 - a * r);
		return r;
	endfunction

	function automatic logic [WordW-1:0] seed_unhash(input logic [WordW-1:0] h);
		logic [WordW-1:0] t;
		t = undo_xorshift(h, 15);
		t = t * odd_inverse(HASH_MUL2);
		t = undo_xorshift(t, 4);
		t = t * odd_inverse(HASH_TIMES);
		return undo_xorshift(t ^ HASH_XOR, 16);
	endfunction

	task automatic send_item(input logic m, input logic [WordW-1:0] a,
			input logic [WordW-1:0] b);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 10) begin
				in_valid <= 1'b0;
				mode <= 1'($urandom_range(0, 1));
				seed_a <= $urandom();
				seed_b <= $urandom();
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= m;
		seed_a <= a;
		seed_b <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 10);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("[mwc_random_generator] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [WordW-1:0] trap_seeds[4];
		int unsigned      pick;

		trap_seeds[0] = seed_unhash('0);
		trap_seeds[1] = seed_unhash(BAD_W);
		trap_seeds[2] = seed_unhash(BAD_Z);
		trap_seeds[3] = seed_unhash('1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Draws straight from the reset state, then seeds at the field extremes.
		send_item(MODE_DRAW, '1, '1);
		send_item(MODE_DRAW, '0, '0);
		send_item(MODE_SEED, '0, '0);
		send_item(MODE_DRAW, '1, '0);
		send_item(MODE_SEED, '1, '1);
		send_item(MODE_DRAW, '0, '1);
		// Seeds whose hash lands on zero, then on each stream's bad value.
		send_item(MODE_SEED, trap_seeds[0], trap_seeds[0]);
		send_item(MODE_DRAW, '0, '0);
		send_item(MODE_SEED, trap_seeds[1], trap_seeds[2]);
		send_item(MODE_DRAW, '0, '0);
		// Bad values swapped between streams must load unchanged.
		send_item(MODE_SEED, trap_seeds[2], trap_seeds[1]);
		send_item(MODE_DRAW, '0, '0);
		// All-ones state words exercise the largest product plus carry.
		send_item(MODE_SEED, trap_seeds[3], trap_seeds[3]);
		send_item(MODE_DRAW, '0, '0);
		send_item(MODE_DRAW, '1, '1);
		send_item(MODE_SEED, $urandom(), $urandom());
		send_item(MODE_SEED, $urandom(), $urandom());
		send_item(MODE_DRAW, $urandom(), $urandom());

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle <= (n >= 500 && n < 850);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_item(MODE_DRAW, $urandom(), $urandom());
			end else if (pick < 95) begin
				send_item(MODE_SEED, $urandom(), $urandom());
			end else begin
				send_item(MODE_SEED, trap_seeds[$urandom_range(0, 3)],
					trap_seeds[$urandom_range(0, 3)]);
			end
		end

		in_valid <= 1'b0;
		no_idle <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[mwc_random_generator] OK");
		end else begin
			$display("[mwc_random_generator] ERROR");
		end
		$finish;
	end

endmodule
